/* design/assert_macros.svh */
// Concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked only out of reset
`define ASSERT_RUN(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// Checked on every edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* design/boxavg_pkg.sv */
package boxavg_pkg;

    localparam int FRAME_CFG_W  = 13;
    localparam int OUTW_CFG_W   = 8;
    localparam int OUTH_CFG_W   = 13;
    localparam int BLOCK_CFG_W  = 7;
    localparam int SCALE_W      = 25;
    localparam int CFG_DATA_W   = 25;
    localparam int CFG_IDX_W    = 3;

    localparam int PIX_W        = 8;
    localparam int IN_TDATA_W   = 24;

    localparam int LEVEL_W      = 16;
    localparam int BCOL_OUT_W   = 7;
    localparam int BROW_OUT_W   = 12;
    localparam int OUT_FIELDS_W = 3 * LEVEL_W + BCOL_OUT_W + BROW_OUT_W;
    localparam int OUT_TDATA_W  = 72;

    localparam int ROW_SUM_W    = 14;
    localparam int COL_SUM_W    = 20;
    localparam int PROD_W       = COL_SUM_W + SCALE_W;
    localparam int FRAC_W       = 16;

    localparam logic [FRAME_CFG_W-1:0] FRAME_WIDTH_RST  = 13'd800;
    localparam logic [FRAME_CFG_W-1:0] FRAME_HEIGHT_RST = 13'd600;
    localparam logic [OUTW_CFG_W-1:0]  OUT_WIDTH_RST    = 8'd80;
    localparam logic [OUTH_CFG_W-1:0]  OUT_HEIGHT_RST   = 13'd60;
    localparam logic [BLOCK_CFG_W-1:0] BLOCK_WIDTH_RST  = 7'd10;
    localparam logic [BLOCK_CFG_W-1:0] BLOCK_HEIGHT_RST = 7'd10;
    localparam logic [SCALE_W-1:0]     SCALE_RST        = 25'd168428;

    localparam logic [PROD_W:0]        ROUND_HALF       = (PROD_W + 1)'(32768);
    localparam logic [LEVEL_W-1:0]     LEVEL_MAX        = 16'hFFFF;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_FRAME_WIDTH  = 3'd0,
        REG_FRAME_HEIGHT = 3'd1,
        REG_OUT_WIDTH    = 3'd2,
        REG_OUT_HEIGHT   = 3'd3,
        REG_BLOCK_WIDTH  = 3'd4,
        REG_BLOCK_HEIGHT = 3'd5,
        REG_SCALE        = 3'd6
    } cfg_reg_t;

    typedef struct packed {
        logic [ROW_SUM_W-1:0] red;
        logic [ROW_SUM_W-1:0] green;
        logic [ROW_SUM_W-1:0] blue;
    } row_sum_t;

    typedef struct packed {
        logic [COL_SUM_W-1:0] blue;
        logic [COL_SUM_W-1:0] green;
        logic [COL_SUM_W-1:0] red;
    } col_sum_t;

    typedef struct packed {
        logic [BCOL_OUT_W-1:0] block_column;
        logic [BROW_OUT_W-1:0] block_row;
        logic                  last_of_frame;
    } blk_tag_t;

endpackage

/* design/box_average_downsampler.sv */
// Channel  | Dir | Payload (low bit up)                                        | Handshake
// s_       | in  | tdata: blue[7:0] green[15:8] red[23:16]                      | tvalid/tready
// m_       | out | tdata: red_level green_level blue_level block_column         | tvalid/tready
//          |     |       block_row, zero pad; tlast: last_of_frame              |
// cfg_     | in  | cfg_index selects register, cfg_wdata value                  | cfg_we
//
// One pixel per cycle unless stalled; a result goes through stages s1, s2, s3 and output.
// The rate is set by the column-sum memory: one read and one write per cycle, with the
// write of a block column forwarded to a read of the same column in the same cycle.
// Reset clears counters, row sums and pipeline valids and loads config defaults; the
// column-sum memory is not cleared, as the first line of every block row discards its read.
// Input stalls only when a result waits at the output and another sits right behind it.
module box_average_downsampler
    import boxavg_pkg::*;
#(
    parameter int MAX_OUT_COLUMNS = 128,
    parameter int MAX_BLOCK_SIDE  = 64,
    parameter int MAX_FRAME_SIDE  = 4096
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   s_tvalid,
    output logic                   s_tready,
    input  logic [IN_TDATA_W-1:0]  s_tdata,   // blue, green, red
    output logic                   m_tvalid,
    input  logic                   m_tready,
    output logic [OUT_TDATA_W-1:0] m_tdata,   // red_level, green_level, blue_level,
                                              // block_column, block_row, zero pad
    output logic                   m_tlast,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_wdata
);

    localparam int FS_W   = $clog2(MAX_FRAME_SIDE + 1);
    localparam int PC_W   = $clog2(MAX_FRAME_SIDE);
    localparam int OW_W   = $clog2(MAX_OUT_COLUMNS + 1);
    localparam int BC_W   = (PC_W > OW_W) ? PC_W : OW_W;
    localparam int BS_W   = $clog2(MAX_BLOCK_SIDE + 1);
    localparam int SB_W   = (MAX_BLOCK_SIDE > 1) ? $clog2(MAX_BLOCK_SIDE) : 1;
    localparam int ADDR_W = (MAX_OUT_COLUMNS > 1) ? $clog2(MAX_OUT_COLUMNS) : 1;
    localparam int CS_W   = 3 * COL_SUM_W;

    logic [FRAME_CFG_W-1:0] frame_width_reg, frame_height_reg;
    logic [OUTW_CFG_W-1:0]  out_width_reg;
    logic [OUTH_CFG_W-1:0]  out_height_reg;
    logic [BLOCK_CFG_W-1:0] block_width_reg, block_height_reg;
    logic [SCALE_W-1:0]     scale_reg;

    logic [FS_W-1:0] fw, fh, oh;
    logic [OW_W-1:0] ow;
    logic [BS_W-1:0] bw, bh;

    logic [PC_W-1:0] pixel_column_reg, pixel_row_reg, block_col_reg, block_row_reg;
    logic [SB_W-1:0] sub_column_reg, sub_row_reg;
    row_sum_t        row_sum_reg, row_sum_next;

    logic            advance, accept, active, line_end, last_line, col_wrap, row_wrap;
    logic [PIX_W-1:0] pix_b, pix_g, pix_r;

    logic [CS_W-1:0]   col_mem [MAX_OUT_COLUMNS];
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;
    logic [CS_W-1:0]   rd_data_reg;
    logic              fwd_hit_reg;
    col_sum_t          fwd_data_reg;

    logic              s1_valid_reg, s1_first_reg, s1_last_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    row_sum_t          s1_row_reg;
    blk_tag_t          s1_tag_reg;
    col_sum_t          s1_base, s1_sum;
    logic              wr_en;

    logic              s2_valid_reg;
    col_sum_t          s2_sum_reg;
    blk_tag_t          s2_tag_reg;

    logic              s3_valid_reg;
    logic [PROD_W-1:0] s3_prod_r_reg, s3_prod_g_reg, s3_prod_b_reg;
    blk_tag_t          s3_tag_reg;

    logic                    m_tvalid_reg;
    logic [LEVEL_W-1:0]      lvl_r_reg, lvl_g_reg, lvl_b_reg;
    blk_tag_t                m_tag_reg;

    function automatic logic [LEVEL_W-1:0] level_of(input logic [PROD_W-1:0] prod);
        logic [PROD_W:0] rounded;
        rounded = {1'b0, prod} + ROUND_HALF;
        if (|rounded[PROD_W:FRAC_W + LEVEL_W]) begin
            return LEVEL_MAX;
        end
        return rounded[FRAC_W + LEVEL_W - 1:FRAC_W];
    endfunction

    // clamp live register values into their legal ranges
    always_comb begin
        fw = (frame_width_reg == '0) ? FS_W'(1) :
             (32'(frame_width_reg) > MAX_FRAME_SIDE) ? FS_W'(MAX_FRAME_SIDE) :
             FS_W'(frame_width_reg);
        fh = (frame_height_reg == '0) ? FS_W'(1) :
             (32'(frame_height_reg) > MAX_FRAME_SIDE) ? FS_W'(MAX_FRAME_SIDE) :
             FS_W'(frame_height_reg);
        oh = (out_height_reg == '0) ? FS_W'(1) :
             (32'(out_height_reg) > MAX_FRAME_SIDE) ? FS_W'(MAX_FRAME_SIDE) :
             FS_W'(out_height_reg);
        ow = (out_width_reg == '0) ? OW_W'(1) :
             (32'(out_width_reg) > MAX_OUT_COLUMNS) ? OW_W'(MAX_OUT_COLUMNS) :
             OW_W'(out_width_reg);
        bw = (block_width_reg == '0) ? BS_W'(1) :
             (32'(block_width_reg) > MAX_BLOCK_SIDE) ? BS_W'(MAX_BLOCK_SIDE) :
             BS_W'(block_width_reg);
        bh = (block_height_reg == '0) ? BS_W'(1) :
             (32'(block_height_reg) > MAX_BLOCK_SIDE) ? BS_W'(MAX_BLOCK_SIDE) :
             BS_W'(block_height_reg);
    end

    assign advance  = !(m_tvalid_reg && !m_tready && s3_valid_reg);
    assign s_tready = advance;
    assign accept   = s_tvalid && advance;

    assign pix_b = s_tdata[PIX_W-1:0];
    assign pix_g = s_tdata[2*PIX_W-1:PIX_W];
    assign pix_r = s_tdata[3*PIX_W-1:2*PIX_W];

    assign active    = (BC_W'(block_col_reg) < BC_W'(ow)) && (FS_W'(block_row_reg) < oh);
    assign line_end  = (BS_W'(sub_column_reg) + BS_W'(1)) >= bw;
    assign last_line = (BS_W'(sub_row_reg) + BS_W'(1)) >= bh;
    assign col_wrap  = (FS_W'(pixel_column_reg) + FS_W'(1)) >= fw;
    assign row_wrap  = (FS_W'(pixel_row_reg) + FS_W'(1)) >= fh;

    always_comb begin
        if (sub_column_reg == '0) begin
            row_sum_next.red   = ROW_SUM_W'(pix_r);
            row_sum_next.green = ROW_SUM_W'(pix_g);
            row_sum_next.blue  = ROW_SUM_W'(pix_b);
        end else begin
            row_sum_next.red   = row_sum_reg.red   + ROW_SUM_W'(pix_r);
            row_sum_next.green = row_sum_reg.green + ROW_SUM_W'(pix_g);
            row_sum_next.blue  = row_sum_reg.blue  + ROW_SUM_W'(pix_b);
        end
    end

    assign rd_en   = accept && active && line_end;
    assign rd_addr = ADDR_W'(block_col_reg);
    assign wr_en   = advance && s1_valid_reg;

    // forward the write landing on the same edge as this read
    always_comb begin
        s1_base = fwd_hit_reg ? fwd_data_reg : col_sum_t'(rd_data_reg);
        if (s1_first_reg) begin
            s1_sum.red   = COL_SUM_W'(s1_row_reg.red);
            s1_sum.green = COL_SUM_W'(s1_row_reg.green);
            s1_sum.blue  = COL_SUM_W'(s1_row_reg.blue);
        end else begin
            s1_sum.red   = s1_base.red   + COL_SUM_W'(s1_row_reg.red);
            s1_sum.green = s1_base.green + COL_SUM_W'(s1_row_reg.green);
            s1_sum.blue  = s1_base.blue  + COL_SUM_W'(s1_row_reg.blue);
        end
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            col_mem[s1_addr_reg] <= s1_sum;
        end
        if (rd_en) begin
            rd_data_reg  <= col_mem[rd_addr];
            fwd_hit_reg  <= wr_en && (s1_addr_reg == rd_addr);
            fwd_data_reg <= s1_sum;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            frame_width_reg  <= FRAME_WIDTH_RST;
            frame_height_reg <= FRAME_HEIGHT_RST;
            out_width_reg    <= OUT_WIDTH_RST;
            out_height_reg   <= OUT_HEIGHT_RST;
            block_width_reg  <= BLOCK_WIDTH_RST;
            block_height_reg <= BLOCK_HEIGHT_RST;
            scale_reg        <= SCALE_RST;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_FRAME_WIDTH:  frame_width_reg  <= cfg_wdata[FRAME_CFG_W-1:0];
                REG_FRAME_HEIGHT: frame_height_reg <= cfg_wdata[FRAME_CFG_W-1:0];
                REG_OUT_WIDTH:    out_width_reg    <= cfg_wdata[OUTW_CFG_W-1:0];
                REG_OUT_HEIGHT:   out_height_reg   <= cfg_wdata[OUTH_CFG_W-1:0];
                REG_BLOCK_WIDTH:  block_width_reg  <= cfg_wdata[BLOCK_CFG_W-1:0];
                REG_BLOCK_HEIGHT: block_height_reg <= cfg_wdata[BLOCK_CFG_W-1:0];
                REG_SCALE:        scale_reg        <= cfg_wdata[SCALE_W-1:0];
                default: ;
            endcase
        end
    end

    // raster and block position
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pixel_column_reg <= '0;
            pixel_row_reg    <= '0;
            block_col_reg    <= '0;
            block_row_reg    <= '0;
            sub_column_reg   <= '0;
            sub_row_reg      <= '0;
            row_sum_reg      <= '0;
        end else if (accept) begin
            if (active) begin
                row_sum_reg <= row_sum_next;
            end
            if (col_wrap) begin
                pixel_column_reg <= '0;
                sub_column_reg   <= '0;
                block_col_reg    <= '0;
                if (row_wrap) begin
                    pixel_row_reg <= '0;
                    sub_row_reg   <= '0;
                    block_row_reg <= '0;
                end else begin
                    pixel_row_reg <= pixel_row_reg + PC_W'(1);
                    if (last_line) begin
                        sub_row_reg   <= '0;
                        block_row_reg <= block_row_reg + PC_W'(1);
                    end else begin
                        sub_row_reg <= sub_row_reg + SB_W'(1);
                    end
                end
            end else begin
                pixel_column_reg <= pixel_column_reg + PC_W'(1);
                if (line_end) begin
                    sub_column_reg <= '0;
                    block_col_reg  <= block_col_reg + PC_W'(1);
                end else begin
                    sub_column_reg <= sub_column_reg + SB_W'(1);
                end
            end
        end
    end

    // valids of the result pipeline
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            s3_valid_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (advance) begin
                s1_valid_reg <= rd_en;
                s2_valid_reg <= s1_valid_reg && s1_last_reg;
                s3_valid_reg <= s2_valid_reg;
            end
            if (advance && s3_valid_reg) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            s1_first_reg             <= (sub_row_reg == '0);
            s1_last_reg              <= last_line;
            s1_addr_reg              <= rd_addr;
            s1_row_reg               <= row_sum_next;
            s1_tag_reg.block_column  <= BCOL_OUT_W'(block_col_reg);
            s1_tag_reg.block_row     <= BROW_OUT_W'(block_row_reg);
            s1_tag_reg.last_of_frame <= (BC_W'(block_col_reg) + BC_W'(1) == BC_W'(ow)) &&
                                        (FS_W'(block_row_reg) + FS_W'(1) == oh);

            s2_sum_reg    <= s1_sum;
            s2_tag_reg    <= s1_tag_reg;

            s3_prod_r_reg <= PROD_W'(s2_sum_reg.red)   * PROD_W'(scale_reg);
            s3_prod_g_reg <= PROD_W'(s2_sum_reg.green) * PROD_W'(scale_reg);
            s3_prod_b_reg <= PROD_W'(s2_sum_reg.blue)  * PROD_W'(scale_reg);
            s3_tag_reg    <= s2_tag_reg;

            if (s3_valid_reg) begin
                lvl_r_reg <= level_of(s3_prod_r_reg);
                lvl_g_reg <= level_of(s3_prod_g_reg);
                lvl_b_reg <= level_of(s3_prod_b_reg);
                m_tag_reg <= s3_tag_reg;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tlast  = m_tag_reg.last_of_frame;
    assign m_tdata  = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), m_tag_reg.block_row,
                       m_tag_reg.block_column, lvl_b_reg, lvl_g_reg, lvl_r_reg};

endmodule

/* design/boxavg_checker.sv */
`include "assert_macros.svh"

module boxavg_checker
    import boxavg_pkg::*;
(
    input logic                   aclk,
    input logic                   aresetn,
    input logic                   s_tready,
    input logic                   m_tvalid,
    input logic                   m_tready,
    input logic [OUT_TDATA_W-1:0] m_tdata,
    input logic                   m_tlast
);

    `ASSERT_RUN(a_out_hold, aclk, aresetn, m_tvalid && !m_tready |=> m_tvalid, "result beat dropped while stalled")
    `ASSERT_RUN(a_out_stable, aclk, aresetn, m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tlast), "result beat changed while stalled")
    `ASSERT_RUN(a_in_free, aclk, aresetn, !m_tvalid || m_tready |-> s_tready, "input blocked with output free")
    `ASSERT_ALWAYS(a_reset_idle, aclk, !aresetn |=> !m_tvalid, "result beat shown after reset")

endmodule

bind box_average_downsampler boxavg_checker u_boxavg_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);
